FILE: sv/prsd_pkg.sv
package prsd_pkg;

  // Palette geometry
  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned PalIdxW = (PaletteEntries > 1) ? $clog2(PaletteEntries) : 1;

  // Queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Transparent run colour and alpha codes
  localparam logic [7:0] TransRed   = 8'hBE;
  localparam logic [7:0] TransGreen = 8'h3C;
  localparam logic [7:0] TransBlue  = 8'hBE;
  localparam logic [7:0] AlphaClear = 8'h00;
  localparam logic [7:0] AlphaOpaque = 8'hFF;

  // Input command codes
  localparam logic CmdPalWrite = 1'b0;
  localparam logic CmdBody     = 1'b1;

  // Result kinds
  localparam logic KindOpaque = 1'b0;
  localparam logic KindRun    = 1'b1;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_COUNT,
    PH_LIT
  } phase_e;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_PIXEL,
    OP_SKIP
  } op_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] palette_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] body_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic       pixel_kind;
    logic [7:0] run_length;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_item_t;

  // Operation handed from front to back
  typedef struct packed {
    op_e         op;
    logic [7:0]  addr;
    logic [23:0] color;
    logic [7:0]  count;
  } op_t;

endpackage

FILE: sv/palette_rle_sprite_decoder.sv
// Path: an item passes the queue, the lookup stage and the output register.
// Throughput: one item per cycle; the front end stalls only when the 4-entry
//   queue fills while the output is held, palette writes use one back-end slot.
// Reset (rst_ni, asynchronous, active low) clears mode, parser, queue and
//   valid flags; the palette holds no reset and is defined once written.
module palette_rle_sprite_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  prsd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output prsd_pkg::out_item_t out_data_o
);
  import prsd_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  op_t  push_op, pop_op;

  prsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_op_o      (push_op)
  );

  prsd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .pop_op_o  (pop_op)
  );

  prsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_op_i      (pop_op),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: sv/prsd_front.sv
module prsd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  prsd_pkg::in_item_t in_data_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output prsd_pkg::op_t    q_op_o
);
  import prsd_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] lit_q, lit_d;
  logic       mode_q;
  logic       accept;
  phase_e     phase_eff;
  logic [7:0] lit_eff;
  logic [7:0] lit_dec;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Restart the parser on the first byte of a sprite
  assign phase_eff = in_data_i.first_byte ? PH_SKIP : phase_q;
  assign lit_eff   = in_data_i.first_byte ? 8'd0 : lit_q;
  assign lit_dec   = lit_eff - 8'd1;

  // Hold the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Next parser state
  always_comb begin
    phase_d = phase_q;
    lit_d   = lit_q;
    if (accept && in_data_i.cmd == CmdBody) begin
      phase_d = phase_eff;
      lit_d   = lit_eff;
      if (mode_q) begin
        unique case (phase_eff)
          PH_COUNT: begin
            if (in_data_i.body_byte == 8'd0) begin
              phase_d = PH_SKIP;
            end else begin
              lit_d   = in_data_i.body_byte;
              phase_d = PH_LIT;
            end
          end
          PH_LIT: begin
            lit_d = lit_dec;
            if (lit_dec == 8'd0) begin
              phase_d = PH_SKIP;
            end
          end
          default: begin
            phase_d = PH_COUNT;
          end
        endcase
      end
    end
  end

  // Classify the item into a back-end operation
  always_comb begin
    q_push_o       = 1'b0;
    q_op_o.op      = OP_PIXEL;
    q_op_o.addr    = in_data_i.body_byte;
    q_op_o.color   = {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
    q_op_o.count   = in_data_i.body_byte;
    if (in_data_i.cmd == CmdPalWrite) begin
      q_push_o    = accept;
      q_op_o.op   = OP_WRITE;
      q_op_o.addr = in_data_i.palette_index;
    end else if (!mode_q) begin
      q_push_o = accept;
    end else begin
      unique case (phase_eff)
        PH_COUNT: begin
          q_push_o = 1'b0;
        end
        PH_LIT: begin
          q_push_o = accept;
        end
        default: begin
          q_push_o  = accept && (in_data_i.body_byte != 8'd0);
          q_op_o.op = OP_SKIP;
        end
      endcase
    end
  end

  // Advance the parser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      lit_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
    end
  end

endmodule

FILE: sv/prsd_queue.sv
module prsd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  prsd_pkg::op_t push_op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output prsd_pkg::op_t pop_op_o
);
  import prsd_pkg::*;

  op_t              mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o   = (count_q == QCntW'(QueueDepth));
  assign empty_o  = (count_q == '0);
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && !empty_o;
  assign pop_op_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

FILE: sv/prsd_back.sv
module prsd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  prsd_pkg::op_t       q_op_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output prsd_pkg::out_item_t out_data_o
);
  import prsd_pkg::*;

  logic [23:0]        pal_q [PaletteEntries];
  logic [23:0]        rd_q;
  logic               s1_valid_q;
  logic               s1_run_q;
  logic [7:0]         s1_count_q;
  logic               s1_in_range_q;
  logic               out_valid_q;
  out_item_t          out_q, out_d;
  logic               s1_adv;
  logic               in_range;
  logic [PalIdxW-1:0] pal_idx;

  assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign q_pop_o  = !q_empty_i && (!s1_valid_q || s1_adv);
  assign in_range = ({1'b0, q_op_i.addr} < 9'(PaletteEntries));
  assign pal_idx  = q_op_i.addr[PalIdxW-1:0];

  // Palette write and registered read
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (q_op_i.op == OP_WRITE) begin
        if (in_range) begin
          pal_q[pal_idx] <= q_op_i.color;
        end
      end else begin
        rd_q <= pal_q[pal_idx];
      end
    end
  end

  // Hold the lookup stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      s1_valid_q <= (q_op_i.op != OP_WRITE);
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_run_q      <= (q_op_i.op == OP_SKIP);
      s1_count_q    <= q_op_i.count;
      s1_in_range_q <= in_range;
    end
  end

  // Form the result item
  always_comb begin
    if (s1_run_q) begin
      out_d.pixel_kind = KindRun;
      out_d.run_length = s1_count_q;
      out_d.red        = TransRed;
      out_d.green      = TransGreen;
      out_d.blue       = TransBlue;
      out_d.alpha      = AlphaClear;
    end else begin
      out_d.pixel_kind = KindOpaque;
      out_d.run_length = 8'd1;
      out_d.red        = s1_in_range_q ? rd_q[23:16] : 8'd0;
      out_d.green      = s1_in_range_q ? rd_q[15:8] : 8'd0;
      out_d.blue       = s1_in_range_q ? rd_q[7:0] : 8'd0;
      out_d.alpha      = AlphaOpaque;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/prsd_checker.sv
module prsd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input prsd_pkg::out_item_t out_data_o
);
  import prsd_pkg::*;

  // Hold a stalled result item
  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // Opaque pixels stand for one pixel at full alpha
  a_opaque_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pixel_kind == KindOpaque |->
      out_data_o.alpha == AlphaOpaque && out_data_o.run_length == 8'd1)
    else $error("malformed opaque pixel");

  // Transparent runs carry the fixed colour and a nonzero length
  a_run_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pixel_kind == KindRun |->
      out_data_o.alpha == AlphaClear && out_data_o.run_length != 8'd0 &&
      out_data_o.red == TransRed && out_data_o.green == TransGreen &&
      out_data_o.blue == TransBlue)
    else $error("malformed transparent run");

endmodule

bind palette_rle_sprite_decoder prsd_checker u_prsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: dv/palette_rle_sprite_decoder_test.sv
`timescale 1ns / 100ps

module palette_rle_sprite_decoder_test;
  import prsd_pkg::*;

  localparam int unsigned DirRows       = 25;
  localparam int unsigned PhaseItems    = 200;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned IdleGap       = 8;
  localparam int unsigned WatchdogLimit = 4000;

  localparam out_item_t NoPixel = '0;

  typedef struct packed {
    logic      mode;
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b1;
  out_item_t out_data_o;

  // Row qualifiers travelling with the item on the input channel
  logic      row_typed = 1'b0;
  out_item_t row_want = '0;

  // Decoder shadow state
  logic [23:0] shade_mem [256];
  bit          written [256];
  logic        tmode = 1'b0;
  phase_e      parse_ph = PH_SKIP;
  logic [7:0]  lits_left = '0;

  out_item_t   pixel_q [$];
  dir_row_t    dir_tab [DirRows];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_errors = 0;
  int unsigned n_items = 0;
  int unsigned n_pal = 0;
  int unsigned n_pixels = 0;
  int unsigned n_runs = 0;
  int unsigned n_cfg = 0;
  int unsigned quiet_cycles = 0;

  palette_rle_sprite_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic in_item_t pal_wr(input logic [7:0] idx, input logic [7:0] r,
                                      input logic [7:0] g, input logic [7:0] b,
                                      input logic first);
    in_item_t it;
    it = '0;
    it.cmd = CmdPalWrite;
    it.palette_index = idx;
    it.red_in = r;
    it.green_in = g;
    it.blue_in = b;
    it.first_byte = first;
    return it;
  endfunction

  function automatic in_item_t body(input logic [7:0] value, input logic first);
    in_item_t it;
    it = '0;
    it.cmd = CmdBody;
    it.body_byte = value;
    it.first_byte = first;
    return it;
  endfunction

  function automatic out_item_t opaque(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    return '{KindOpaque, 8'd1, r, g, b, AlphaOpaque};
  endfunction

  function automatic out_item_t clear_run(input logic [7:0] len);
    return '{KindRun, len, TransRed, TransGreen, TransBlue, AlphaClear};
  endfunction

  // Apply one accepted item to the shadow state and work out its pixel
  task automatic decode_item(input in_item_t it, output logic has_px, output out_item_t px);
    logic [23:0] c;
    has_px = 1'b0;
    px = '0;
    if (it.cmd == CmdPalWrite) begin
      if (it.palette_index < PaletteEntries) begin
        shade_mem[it.palette_index] = {it.red_in, it.green_in, it.blue_in};
        written[it.palette_index] = 1'b1;
      end
    end else begin
      if (it.first_byte) begin
        parse_ph = PH_SKIP;
        lits_left = '0;
      end
      if (!tmode || parse_ph == PH_LIT) begin
        c = (it.body_byte < PaletteEntries) ? shade_mem[it.body_byte] : 24'h0;
        px = opaque(c[23:16], c[15:8], c[7:0]);
        has_px = 1'b1;
        if (tmode) begin
          lits_left = lits_left - 8'd1;
          if (lits_left == 8'd0) parse_ph = PH_SKIP;
        end
      end else if (parse_ph == PH_COUNT) begin
        if (it.body_byte == 8'd0) begin
          parse_ph = PH_SKIP;
        end else begin
          lits_left = it.body_byte;
          parse_ph = PH_LIT;
        end
      end else begin
        parse_ph = PH_COUNT;
        if (it.body_byte != 8'd0) begin
          px = clear_run(it.body_byte);
          has_px = 1'b1;
        end
      end
    end
  endtask

  // Pick a palette entry that has already been written, else entry 0 after 32 misses
  function automatic logic [7:0] pick_shade();
    logic [7:0] k;
    for (int t = 0; t < 32; t++) begin
      k = 8'($urandom_range(0, 255));
      if (written[k]) return k;
    end
    return 8'h00;
  endfunction

  // Build the next random item, following the parser so sequences stay mostly well formed
  task automatic next_item(output in_item_t it);
    phase_e      ph;
    int unsigned r;
    it.cmd = CmdBody;
    it.palette_index = 8'($urandom_range(0, 255));
    it.red_in = 8'($urandom_range(0, 255));
    it.green_in = 8'($urandom_range(0, 255));
    it.blue_in = 8'($urandom_range(0, 255));
    it.body_byte = 8'($urandom_range(0, 255));
    it.first_byte = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 10) begin
      it.cmd = CmdPalWrite;
    end else begin
      it.first_byte = ($urandom_range(0, 99) < 5);
      ph = it.first_byte ? PH_SKIP : parse_ph;
      r = $urandom_range(0, 99);
      if (!tmode || ph == PH_LIT) begin
        it.body_byte = pick_shade();
      end else if (ph == PH_COUNT) begin
        if (r < 10) it.body_byte = 8'd0;
        else if (r < 95) it.body_byte = 8'($urandom_range(1, 6));
        else it.body_byte = 8'($urandom_range(7, 255));
      end else begin
        if (r < 15) it.body_byte = 8'd0;
        else if (r < 80) it.body_byte = 8'($urandom_range(1, 16));
        else it.body_byte = 8'($urandom_range(17, 255));
      end
    end
  endtask

  // Present one item and hold it until accepted; entered and left at a falling edge
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = it;
    row_typed = typed;
    row_want = want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drain, let the back end settle, then write the mode register
  task automatic set_mode(input logic m);
    in_valid_i = 1'b0;
    while (pixel_q.size() != 0) @(negedge clk_i);
    repeat (IdleGap) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = m;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tmode = m;
    n_cfg++;
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // Receiver stalls
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Predict on input acceptance, compare on output acceptance
  always @(posedge clk_i) begin : monitor
    logic      has_px;
    out_item_t px;
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        decode_item(in_data_i, has_px, px);
        if (row_typed) pixel_q.insert(pixel_q.size(), row_want);
        else if (has_px) pixel_q.insert(pixel_q.size(), px);
        n_items++;
        if (in_data_i.cmd == CmdPalWrite) n_pal++;
      end
      if (out_valid_o && out_ready_i) begin
        n_pixels++;
        if (out_data_o.pixel_kind == KindRun) n_runs++;
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel %0h", out_data_o);
          n_errors++;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_kind", 8'(want.pixel_kind), 8'(out_data_o.pixel_kind));
          check_field("run_length", want.run_length, out_data_o.run_length);
          check_field("red", want.red, out_data_o.red);
          check_field("green", want.green, out_data_o.green);
          check_field("blue", want.blue, out_data_o.blue);
          check_field("alpha", want.alpha, out_data_o.alpha);
        end
      end
    end
  end

  // Watchdog on cycles with no traffic on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t it;
    // Plain mode: table extremes, first byte flag, rewrite of a read entry
    dir_tab[0]  = {1'b0, pal_wr(8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0, NoPixel};
    dir_tab[1]  = {1'b0, pal_wr(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0), 1'b0, NoPixel};
    dir_tab[2]  = {1'b0, pal_wr(8'h5A, 8'h12, 8'h34, 8'h56, 1'b0), 1'b0, NoPixel};
    dir_tab[3]  = {1'b0, body(8'h00, 1'b1), 1'b1, opaque(8'h00, 8'h00, 8'h00)};
    dir_tab[4]  = {1'b0, body(8'hFF, 1'b0), 1'b1, opaque(8'hFF, 8'hFF, 8'hFF)};
    dir_tab[5]  = {1'b0, body(8'h5A, 1'b0), 1'b1, opaque(8'h12, 8'h34, 8'h56)};
    dir_tab[6]  = {1'b0, pal_wr(8'h5A, 8'hA5, 8'hC3, 8'h0F, 1'b0), 1'b0, NoPixel};
    dir_tab[7]  = {1'b0, body(8'h5A, 1'b0), 1'b1, opaque(8'hA5, 8'hC3, 8'h0F)};
    // Run-coded: zero skip, zero count, widest skip, literals at the extremes
    dir_tab[8]  = {1'b1, body(8'h00, 1'b1), 1'b0, NoPixel};
    dir_tab[9]  = {1'b1, body(8'h00, 1'b0), 1'b0, NoPixel};
    dir_tab[10] = {1'b1, body(8'hFF, 1'b0), 1'b1, clear_run(8'hFF)};
    dir_tab[11] = {1'b1, body(8'h02, 1'b0), 1'b0, NoPixel};
    dir_tab[12] = {1'b1, body(8'h00, 1'b0), 1'b1, opaque(8'h00, 8'h00, 8'h00)};
    dir_tab[13] = {1'b1, body(8'hFF, 1'b0), 1'b1, opaque(8'hFF, 8'hFF, 8'hFF)};
    dir_tab[14] = {1'b1, body(8'h01, 1'b0), 1'b1, clear_run(8'h01)};
    dir_tab[15] = {1'b1, body(8'hFF, 1'b0), 1'b0, NoPixel};
    dir_tab[16] = {1'b1, body(8'h5A, 1'b0), 1'b0, NoPixel};
    // Restart in the middle of a literal run
    dir_tab[17] = {1'b1, body(8'h03, 1'b1), 1'b1, clear_run(8'h03)};
    dir_tab[18] = {1'b1, body(8'h01, 1'b0), 1'b0, NoPixel};
    // Mode change mid sprite keeps the pending literal
    dir_tab[19] = {1'b0, body(8'hFF, 1'b0), 1'b1, opaque(8'hFF, 8'hFF, 8'hFF)};
    dir_tab[20] = {1'b1, body(8'h00, 1'b0), 1'b1, opaque(8'h00, 8'h00, 8'h00)};
    dir_tab[21] = {1'b1, body(8'h07, 1'b0), 1'b1, clear_run(8'h07)};
    // Palette write with the first byte flag leaves the parser alone
    dir_tab[22] = {1'b1, pal_wr(8'h01, 8'h01, 8'h02, 8'h03, 1'b1), 1'b0, NoPixel};
    dir_tab[23] = {1'b1, body(8'h01, 1'b0), 1'b0, NoPixel};
    dir_tab[24] = {1'b1, body(8'h01, 1'b0), 1'b1, opaque(8'h01, 8'h02, 8'h03)};

    // Hold reset, then release at a falling edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    set_mode(1'b0);

    // Walk the directed table
    for (int k = 0; k < DirRows; k++) begin
      if (dir_tab[k].mode != tmode) set_mode(dir_tab[k].mode);
      send_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].want);
    end

    // Random phases: toggle the mode, step through the idling patterns
    for (int p = 0; p < NumPhases; p++) begin
      set_mode(p[0] ? 1'b0 : 1'b1);
      case (p / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        next_item(it);
        send_item(it, 1'b0, NoPixel);
      end
    end

    // Drain and let the back end settle
    in_valid_i = 1'b0;
    while (pixel_q.size() != 0) @(negedge clk_i);
    repeat (IdleGap) @(negedge clk_i);

    $display("Ran %0d items (%0d palette writes) through %0d mode writes;",
             n_items, n_pal, n_cfg);
    $display("checked %0d pixels, %0d of them transparent runs.", n_pixels, n_runs);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
